### rtl/dqta_pkg.sv
// Shared types and constants for the dwell-qualified temperature alarm.
// No dependencies; every other file in rtl/ imports this package.
package dqta_pkg;

    localparam int unsigned TempW  = 16;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned LevelW = 2;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 32;

    // Stream payload widths, byte aligned
    localparam int unsigned InDataW   = 48;   // now_time, temperature
    localparam int unsigned InUserW   = 1;    // sample_valid
    localparam int unsigned OutDataW  = 24;   // alarm_level, shown_threshold, prior_level, pad
    localparam int unsigned OutUserW  = 2;    // armed, level_changed

    // Alarm level codes
    localparam logic [LevelW-1:0] LVL_OK   = 2'd0;
    localparam logic [LevelW-1:0] LVL_WARN = 2'd1;
    localparam logic [LevelW-1:0] LVL_CRIT = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_WARN_LEVEL    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_CRIT_LEVEL    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_RESTORE_LEVEL = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_TRIGGER_TIME  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_RESTORE_TIME  = 3'd4;

    // Reset values
    localparam logic signed [TempW-1:0] RST_WARN_LEVEL    = 16'sd600;
    localparam logic signed [TempW-1:0] RST_CRIT_LEVEL    = 16'sd800;
    localparam logic signed [TempW-1:0] RST_RESTORE_LEVEL = 16'sd550;
    localparam logic [TimeW-1:0]        RST_TRIGGER_TIME  = 32'd5000;
    localparam logic [TimeW-1:0]        RST_RESTORE_TIME  = 32'd10000;

    typedef struct packed {
        logic signed [TempW-1:0] warn_level;
        logic signed [TempW-1:0] crit_level;
        logic signed [TempW-1:0] restore_level;
        logic [TimeW-1:0]        trigger_time;
        logic [TimeW-1:0]        restore_time;
    } t_cfg;

    typedef struct packed {
        logic [TimeW-1:0]        last_time;
        logic [TimeW-1:0]        warn_dwell;
        logic [TimeW-1:0]        crit_dwell;
        logic [TimeW-1:0]        restore_dwell;
        logic [LevelW-1:0]       level;
        logic                    armed;
        logic signed [TempW-1:0] threshold;
    } t_state;

    typedef struct packed {
        logic [TimeW-1:0]        now_time;
        logic                    sample_valid;
        logic signed [TempW-1:0] temperature;
    } t_item;

    typedef struct packed {
        logic [LevelW-1:0]       alarm_level;
        logic                    armed;
        logic signed [TempW-1:0] shown_threshold;
        logic                    level_changed;
        logic [LevelW-1:0]       prior_level;
    } t_result;

endpackage

### rtl/dqta_cfg.sv
// Configuration register bank for the temperature alarm.
// Depends on dqta_pkg.
module dqta_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dqta_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [dqta_pkg::CfgDataW-1:0]     i_cfg_data,
    output dqta_pkg::t_cfg                    o_cfg
);
    import dqta_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WARN_LEVEL:    n_cfg.warn_level    = i_cfg_data[TempW-1:0];
                REG_CRIT_LEVEL:    n_cfg.crit_level    = i_cfg_data[TempW-1:0];
                REG_RESTORE_LEVEL: n_cfg.restore_level = i_cfg_data[TempW-1:0];
                REG_TRIGGER_TIME:  n_cfg.trigger_time  = i_cfg_data[TimeW-1:0];
                REG_RESTORE_TIME:  n_cfg.restore_time  = i_cfg_data[TimeW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warn_level    <= RST_WARN_LEVEL;
            r_cfg.crit_level    <= RST_CRIT_LEVEL;
            r_cfg.restore_level <= RST_RESTORE_LEVEL;
            r_cfg.trigger_time  <= RST_TRIGGER_TIME;
            r_cfg.restore_time  <= RST_RESTORE_TIME;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/dqta_eval.sv
// One evaluation step: elapsed time, dwell update, level decision.
// Pure combinational; depends on dqta_pkg.
module dqta_eval (
    input  dqta_pkg::t_cfg    i_cfg,
    input  dqta_pkg::t_state  i_state,
    input  dqta_pkg::t_item   i_item,
    output dqta_pkg::t_state  o_state,
    output dqta_pkg::t_result o_result
);
    import dqta_pkg::*;

    logic [TimeW-1:0] dt;
    logic [TimeW:0]   sum_warn;
    logic [TimeW:0]   sum_crit;
    logic [TimeW:0]   sum_rest;
    logic [TimeW-1:0] sat_warn;
    logic [TimeW-1:0] sat_crit;
    logic [TimeW-1:0] sat_rest;
    t_state           st;

    // last_time of zero means no earlier evaluation
    assign dt = (i_state.last_time == '0) ? '0 : (i_item.now_time - i_state.last_time);

    assign sum_warn = {1'b0, i_state.warn_dwell}    + {1'b0, dt};
    assign sum_crit = {1'b0, i_state.crit_dwell}    + {1'b0, dt};
    assign sum_rest = {1'b0, i_state.restore_dwell} + {1'b0, dt};
    assign sat_warn = sum_warn[TimeW] ? '1 : sum_warn[TimeW-1:0];
    assign sat_crit = sum_crit[TimeW] ? '1 : sum_crit[TimeW-1:0];
    assign sat_rest = sum_rest[TimeW] ? '1 : sum_rest[TimeW-1:0];

    always_comb begin
        st           = i_state;
        st.last_time = i_item.now_time;
        if (!i_item.sample_valid) begin
            st.armed         = 1'b0;
            st.level         = LVL_OK;
            st.warn_dwell    = '0;
            st.crit_dwell    = '0;
            st.restore_dwell = '0;
        end else begin
            st.armed     = 1'b1;
            st.threshold = i_cfg.warn_level;
            if (i_item.temperature >= i_cfg.crit_level) begin
                st.crit_dwell    = sat_crit;
                st.warn_dwell    = sat_warn;
                st.restore_dwell = '0;
            end else if (i_item.temperature >= i_cfg.warn_level) begin
                st.warn_dwell    = sat_warn;
                st.crit_dwell    = '0;
                st.restore_dwell = '0;
            end else if (i_item.temperature < i_cfg.restore_level) begin
                st.restore_dwell = sat_rest;
                st.warn_dwell    = '0;
                st.crit_dwell    = '0;
            end else begin
                // hysteresis band: restore dwell holds
                st.warn_dwell = '0;
                st.crit_dwell = '0;
            end

            if (st.crit_dwell >= i_cfg.trigger_time) begin
                st.level     = LVL_CRIT;
                st.threshold = i_cfg.crit_level;
            end else if (st.warn_dwell >= i_cfg.trigger_time) begin
                st.level = LVL_WARN;
            end else if (i_state.level != LVL_OK &&
                         st.restore_dwell >= i_cfg.restore_time) begin
                st.level = LVL_OK;
            end
        end
    end

    assign o_state                  = st;
    assign o_result.alarm_level     = st.level;
    assign o_result.armed           = st.armed;
    assign o_result.shown_threshold = st.threshold;
    assign o_result.level_changed   = (st.level != i_state.level);
    assign o_result.prior_level     = i_state.level;

endmodule

### rtl/dwell_qualified_temperature_alarm_top.sv
// Top level of the dwell-qualified temperature alarm: stream ports,
// input register, alarm state and result register. Uses dqta_pkg, dqta_cfg, dqta_eval.
//
//  channel   dir  handshake                  payload
//  --------  ---  -------------------------  -------------------------------------------
//  s_axis    in   i_s_axis_tvalid/o_..tready  tdata: now_time, temperature; tuser: sample_valid
//  m_axis    out  o_m_axis_tvalid/i_..tready  tdata: alarm_level, shown_threshold, prior_level
//                                             tuser: armed, level_changed
//  cfg       in   i_cfg_we (no wait)          index 0..4, data 32 bit
//
// One transfer in per cycle while the output is not stalled. Items pass the input register, then
// evaluation into the result register, which also commits the alarm state; the state loop
// (dwell add, compare, level) is the combinational path that fixes the rate.
// Reset is synchronous, active low: valid flags and alarm state clear, threshold takes
// the warning level reset value. A stalled output holds both registers and drops
// o_s_axis_tready only once the input register is also full.
module dwell_qualified_temperature_alarm_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [31:0] now_time, [47:32] temperature
    input  logic [dqta_pkg::InDataW-1:0]       i_s_axis_tdata,
    // [0] sample_valid
    input  logic [dqta_pkg::InUserW-1:0]       i_s_axis_tuser,
    // master stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [1:0] alarm_level, [17:2] shown_threshold, [19:18] prior_level, [23:20] zero
    output logic [dqta_pkg::OutDataW-1:0]      o_m_axis_tdata,
    // [0] armed, [1] level_changed
    output logic [dqta_pkg::OutUserW-1:0]      o_m_axis_tuser,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [dqta_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [dqta_pkg::CfgDataW-1:0]      i_cfg_data
);
    import dqta_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_vld;
    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_out_vld;
    logic    advance;
    logic    s_xfer;

    dqta_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    dqta_eval u_eval (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // Item moves from input register to result register when the result
    // slot is free or being drained this cycle.
    assign advance         = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || advance;
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;

    // Input register: payload needs no reset
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_item.now_time     <= i_s_axis_tdata[TimeW-1:0];
            r_item.temperature  <= i_s_axis_tdata[TimeW+TempW-1:TimeW];
            r_item.sample_valid <= i_s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_xfer) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    // Alarm state, committed as each item is evaluated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_time     <= '0;
            r_state.warn_dwell    <= '0;
            r_state.crit_dwell    <= '0;
            r_state.restore_dwell <= '0;
            r_state.level         <= LVL_OK;
            r_state.armed         <= 1'b0;
            r_state.threshold     <= RST_WARN_LEVEL;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {4'b0000, r_res.prior_level, r_res.shown_threshold,
                              r_res.alarm_level};
    assign o_m_axis_tuser  = {r_res.level_changed, r_res.armed};

endmodule

### bench/tb.sv
// Self-checking bench for dwell_qualified_temperature_alarm_top: directed and random
// evaluations with a cycle-free alarm predictor and an in-order result queue.
// Depends on rtl/dqta_pkg.sv and the RTL under rtl/.
module tb;
    import dqta_pkg::*;

    // First register index past the defined set; writes there must be dropped.
    localparam logic [CfgIdxW-1:0] REG_SPARE_FIRST = REG_RESTORE_TIME + 3'd1;
    localparam int unsigned SHOWN_ERRORS = 10;

    // Temperature neighborhoods used to build dwell runs.
    typedef enum int unsigned {
        ZONE_CRIT, ZONE_WARN, ZONE_BAND, ZONE_COOL, ZONE_EDGE, ZONE_ANY
    } t_zone;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // [31:0] now_time, [47:32] temperature
    logic [InDataW-1:0]   i_s_axis_tdata = '0;
    // [0] sample_valid
    logic [InUserW-1:0]   i_s_axis_tuser = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // [1:0] alarm_level, [17:2] shown_threshold, [19:18] prior_level, [23:20] zero
    logic [OutDataW-1:0]  o_m_axis_tdata;
    // [0] armed, [1] level_changed
    logic [OutUserW-1:0]  o_m_axis_tuser;
    logic                 i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]   i_cfg_idx = '0;
    logic [CfgDataW-1:0]  i_cfg_data = '0;

    // Predictor copy of the registers and alarm state
    t_cfg        alarm_cfg;
    t_state      alarm_st;
    t_result     pending_reports[$];
    t_result     oldest_report;

    logic [TimeW-1:0] uptime_ms = '0;      // last now_time sent
    logic [TimeW-1:0] step_ms_max = 32'd1000;
    int unsigned send_gap_pct = 0;        // chance per cycle of an idle input cycle
    int unsigned stall_pct = 0;           // chance per cycle of holding off results
    int unsigned mismatches = 0;
    int unsigned reports_seen = 0;

    dwell_qualified_temperature_alarm_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result-side back-pressure, redrawn every cycle.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic logic [TimeW-1:0] sat_sum(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
        logic [TimeW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TimeW] ? '1 : s[TimeW-1:0];
    endfunction

    task automatic reset_alarm_model();
        alarm_cfg.warn_level    = RST_WARN_LEVEL;
        alarm_cfg.crit_level    = RST_CRIT_LEVEL;
        alarm_cfg.restore_level = RST_RESTORE_LEVEL;
        alarm_cfg.trigger_time  = RST_TRIGGER_TIME;
        alarm_cfg.restore_time  = RST_RESTORE_TIME;
        alarm_st = '0;
        alarm_st.threshold = RST_WARN_LEVEL;
    endtask

    // One evaluation: advance the state and queue the report it must produce.
    task automatic predict_alarm(t_item it);
        t_result           r;
        logic [TimeW-1:0]  elapsed;
        logic [LevelW-1:0] prior;
        prior = alarm_st.level;
        // a stored time of zero means no earlier evaluation
        elapsed = (alarm_st.last_time == '0) ? '0 : it.now_time - alarm_st.last_time;
        alarm_st.last_time = it.now_time;
        if (!it.sample_valid) begin
            // disarm: level to OK, dwells cleared, threshold kept
            alarm_st.armed         = 1'b0;
            alarm_st.level         = LVL_OK;
            alarm_st.warn_dwell    = '0;
            alarm_st.crit_dwell    = '0;
            alarm_st.restore_dwell = '0;
        end else begin
            alarm_st.armed     = 1'b1;
            alarm_st.threshold = alarm_cfg.warn_level;
            if (it.temperature >= alarm_cfg.crit_level) begin
                alarm_st.crit_dwell    = sat_sum(alarm_st.crit_dwell, elapsed);
                alarm_st.warn_dwell    = sat_sum(alarm_st.warn_dwell, elapsed);
                alarm_st.restore_dwell = '0;
            end else if (it.temperature >= alarm_cfg.warn_level) begin
                alarm_st.warn_dwell    = sat_sum(alarm_st.warn_dwell, elapsed);
                alarm_st.crit_dwell    = '0;
                alarm_st.restore_dwell = '0;
            end else if (it.temperature < alarm_cfg.restore_level) begin
                alarm_st.restore_dwell = sat_sum(alarm_st.restore_dwell, elapsed);
                alarm_st.warn_dwell    = '0;
                alarm_st.crit_dwell    = '0;
            end else begin
                // hysteresis band: restore dwell holds
                alarm_st.warn_dwell = '0;
                alarm_st.crit_dwell = '0;
            end
            if (alarm_st.crit_dwell >= alarm_cfg.trigger_time) begin
                alarm_st.level     = LVL_CRIT;
                alarm_st.threshold = alarm_cfg.crit_level;
            end else if (alarm_st.warn_dwell >= alarm_cfg.trigger_time) begin
                alarm_st.level = LVL_WARN;
            end else if (alarm_st.level != LVL_OK &&
                         alarm_st.restore_dwell >= alarm_cfg.restore_time) begin
                alarm_st.level = LVL_OK;
            end
        end
        r.alarm_level     = alarm_st.level;
        r.armed           = alarm_st.armed;
        r.shown_threshold = alarm_st.threshold;
        r.level_changed   = (alarm_st.level != prior);
        r.prior_level     = prior;
        pending_reports.push_back(r);
    endtask

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("report %0d: %s expected %0h got %0h", reports_seen, what, want, got);
    endtask

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) note_mismatch(what, want, got);
    endtask

    // Outputs are sampled at the edge, before the DUT's own updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_reports.size() == 0) begin
                note_mismatch("unrequested report, tdata", '0, 32'(o_m_axis_tdata));
            end else begin
                oldest_report = pending_reports.pop_front();
                check_field("alarm_level", 32'(oldest_report.alarm_level),
                            32'(o_m_axis_tdata[1:0]));
                check_field("shown_threshold", 32'($unsigned(oldest_report.shown_threshold)),
                            32'(o_m_axis_tdata[17:2]));
                check_field("prior_level", 32'(oldest_report.prior_level),
                            32'(o_m_axis_tdata[19:18]));
                check_field("tdata padding", '0, 32'(o_m_axis_tdata[23:20]));
                check_field("armed", 32'(oldest_report.armed), 32'(o_m_axis_tuser[0]));
                check_field("level_changed", 32'(oldest_report.level_changed),
                            32'(o_m_axis_tuser[1]));
            end
            reports_seen++;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // Offer one evaluation, hold it until the transfer, then maybe idle.
    task automatic send_eval(logic [TimeW-1:0] now, logic valid, logic signed [TempW-1:0] temp);
        t_item it;
        it.now_time     = now;
        it.sample_valid = valid;
        it.temperature  = temp;
        i_s_axis_tdata  <= {temp, now};
        i_s_axis_tuser  <= valid;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_alarm(it);
        uptime_ms = now;
        while ($urandom_range(99) < send_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Stop sending and let every queued report come back, then let the
    // two-stage pipe settle.
    task automatic drain_results(int unsigned bound);
        int unsigned waited;
        waited = 0;
        i_s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0 && waited < bound) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Leaves i_cfg_we high; the caller drops it after the last write.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Level registers get random upper bits: only the low 16 count.
    task automatic apply_settings(t_cfg c);
        drain_results(5000);
        write_reg(REG_WARN_LEVEL,    {16'($urandom()), c.warn_level});
        write_reg(REG_CRIT_LEVEL,    {16'($urandom()), c.crit_level});
        write_reg(REG_RESTORE_LEVEL, {16'($urandom()), c.restore_level});
        write_reg(REG_TRIGGER_TIME,  c.trigger_time);
        write_reg(REG_RESTORE_TIME,  c.restore_time);
        i_cfg_we <= 1'b0;
        alarm_cfg = c;
    endtask

    function automatic logic signed [TempW-1:0] pick_temperature(t_zone zone);
        int t;
        int warn;
        int crit;
        int rest;
        int span;
        warn = alarm_cfg.warn_level;
        crit = alarm_cfg.crit_level;
        rest = alarm_cfg.restore_level;
        case (zone)
            ZONE_CRIT: t = crit + int'($urandom_range(300));
            ZONE_WARN: begin
                span = crit - warn;
                t = (span > 1) ? warn + int'($urandom_range(span - 1)) : warn;
            end
            ZONE_BAND: begin
                span = warn - rest;
                t = (span > 1) ? rest + int'($urandom_range(span - 1)) : rest;
            end
            ZONE_COOL: t = rest - 1 - int'($urandom_range(300));
            ZONE_EDGE: begin
                case ($urandom_range(5))
                    0: t = crit;
                    1: t = crit - 1;
                    2: t = warn;
                    3: t = warn - 1;
                    4: t = rest;
                    default: t = rest - 1;
                endcase
            end
            default: t = int'($signed(16'($urandom())));
        endcase
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return 16'(t);
    endfunction

    // Runs of evaluations in one temperature zone so the dwells build up,
    // with the odd invalid sample, zero time, time jump or wild reading.
    task automatic run_random_items(int unsigned count);
        t_zone            zone;
        int unsigned      run_len;
        int unsigned      sent;
        logic [TimeW-1:0] now;
        logic             valid;
        logic signed [TempW-1:0] temp;
        sent = 0;
        while (sent < count) begin
            zone    = t_zone'($urandom_range(ZONE_ANY));
            run_len = $urandom_range(1, 12);
            repeat (run_len) begin
                case ($urandom_range(39))
                    0:       now = '0;
                    1:       now = $urandom();
                    default: now = uptime_ms + $urandom_range(0, step_ms_max);
                endcase
                valid = ($urandom_range(19) != 0);
                temp  = ($urandom_range(9) == 0) ? 16'($urandom()) : pick_temperature(zone);
                send_eval(now, valid, temp);
                sent++;
            end
        end
    endtask

    // Register settings for the random part, from ordinary to degenerate.
    task automatic apply_variant(int unsigned variant);
        t_cfg c;
        int   w;
        w = $urandom_range(1000);
        c.warn_level    = 16'(w);
        c.crit_level    = 16'(w + int'($urandom_range(1, 300)));
        c.restore_level = 16'(w - int'($urandom_range(0, 150)));
        c.trigger_time  = $urandom_range(3000);
        c.restore_time  = $urandom_range(6000);
        step_ms_max     = 32'd1500;
        case (variant)
            1: begin
                // every reading at or over warn, nothing ever cool
                c.warn_level    = 16'sh8000;
                c.crit_level    = 16'sh7fff;
                c.restore_level = 16'sh8000;
                c.trigger_time  = '0;
                c.restore_time  = '1;
                step_ms_max     = 32'd1000;
            end
            2: begin
                // crit below warn, restore at or above warn
                c.crit_level    = 16'(w - int'($urandom_range(1, 200)));
                c.restore_level = 16'(w + int'($urandom_range(0, 200)));
                c.trigger_time  = $urandom_range(2000);
                c.restore_time  = $urandom_range(2000);
                step_ms_max     = 32'd800;
            end
            3: begin
                // only saturated dwells can raise; recovery is immediate
                c.trigger_time = '1;
                c.restore_time = '0;
                step_ms_max    = 32'h7fff_ffff;
            end
            4: begin
                c.warn_level    = 16'sh7fff;
                c.crit_level    = 16'sh8000;
                c.restore_level = 16'sh7fff;
                c.trigger_time  = 32'd1;
                c.restore_time  = 32'd1;
                step_ms_max     = 32'd3;
            end
            5: begin
                // thresholds near or below zero
                w = -int'($urandom_range(500));
                c.warn_level    = 16'(w);
                c.crit_level    = 16'(w + 100);
                c.restore_level = 16'(w - 50);
                c.trigger_time  = 32'd2000;
                c.restore_time  = 32'd4000;
                step_ms_max     = 32'd1000;
            end
            default: ;
        endcase
        apply_settings(c);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // A zero timestamp keeps the stored time at zero, so no dwell accrues.
    task automatic test_time_zero_start();
        send_eval(32'd0, 1'b1, 16'sd700);
        send_eval(32'd0, 1'b1, 16'sd700);
        send_eval(32'd1000, 1'b1, 16'sd700);
    endtask

    // Warning, then critical, hold in the band, then recovery to OK.
    task automatic test_level_escalation();
        send_eval(32'd4000, 1'b1, 16'sd700);
        send_eval(32'd6500, 1'b1, 16'sd900);
        send_eval(32'd9000, 1'b1, 16'sd900);
        send_eval(32'd11000, 1'b1, 16'sd570);
        send_eval(32'd15000, 1'b1, 16'sd500);
        send_eval(32'd22000, 1'b1, 16'sh8000);
        send_eval(32'd23000, 1'b1, 16'sh7fff);
    endtask

    task automatic test_invalid_sample();
        send_eval(32'd24000, 1'b0, 16'sh7fff);
        send_eval(32'd25000, 1'b1, -16'sd1);
    endtask

    // Elapsed time across the 2^32 wrap.
    task automatic test_time_wrap();
        send_eval(32'hffff_f000, 1'b0, 16'sd700);
        send_eval(32'h0000_0800, 1'b1, 16'sd700);
    endtask

    // Dwells pinned at all-ones still meet an all-ones limit.
    task automatic test_dwell_saturation();
        t_cfg c;
        c = alarm_cfg;
        c.trigger_time = '1;
        c.restore_time = '1;
        apply_settings(c);
        send_eval(32'h0000_0001, 1'b1, 16'sh7fff);
        send_eval(32'h8000_0001, 1'b1, 16'sh7fff);
        send_eval(32'h0000_0001, 1'b1, 16'sh8000);
        send_eval(32'h8000_0001, 1'b1, 16'sh8000);
    endtask

    // Zero limits are met at once since the compares are at-or-over.
    task automatic test_zero_dwell_limits();
        t_cfg c;
        c.warn_level    = RST_WARN_LEVEL;
        c.crit_level    = RST_CRIT_LEVEL;
        c.restore_level = RST_RESTORE_LEVEL;
        c.trigger_time  = '0;
        c.restore_time  = '0;
        apply_settings(c);
        send_eval(uptime_ms + 32'd10, 1'b1, 16'sh8000);
        send_eval(uptime_ms + 32'd10, 1'b1, 16'sd0);
        c.trigger_time = 32'd100;
        apply_settings(c);
        send_eval(uptime_ms + 32'd200, 1'b1, 16'sd900);
        send_eval(uptime_ms + 32'd10, 1'b1, 16'sd549);
        send_eval(uptime_ms + 32'd10, 1'b1, 16'sd560);
    endtask

    // Writes to undefined indexes must leave every register alone.
    task automatic test_unknown_register();
        drain_results(5000);
        write_reg(REG_SPARE_FIRST, '1);
        write_reg(REG_SPARE_FIRST + 3'd1, '0);
        write_reg(REG_SPARE_FIRST + 3'd2, $urandom());
        i_cfg_we <= 1'b0;
        send_eval(uptime_ms + 32'd50, 1'b1, 16'sd900);
    endtask

    task automatic test_random_traffic(int unsigned gap_pct, int unsigned hold_pct,
                                       int unsigned first_variant);
        send_gap_pct = gap_pct;
        stall_pct    = hold_pct;
        apply_variant(first_variant);
        run_random_items(75);
        apply_variant(first_variant + 1);
        run_random_items(75);
    endtask

    initial begin
        reset_alarm_model();
        send_gap_pct = 15;
        stall_pct    = 71;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_time_zero_start();
        test_level_escalation();
        test_invalid_sample();
        test_time_wrap();
        test_dwell_saturation();
        test_zero_dwell_limits();
        test_unknown_register();
        test_random_traffic(15, 71, 0);
        test_random_traffic(71, 15, 2);
        test_random_traffic(0, 0, 4);

        drain_results(20000);
        if (pending_reports.size() != 0) begin
            $display("%0d reports never arrived", pending_reports.size());
            mismatches += pending_reports.size();
        end
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
